>>> design/sacl_pkg.sv
// sacl_pkg: shared types and constants for the set-associative LRU tag array
// holds the sequencer state type, register indexes, field widths and defaults
// no dependencies
package sacl_pkg;

	// defaults for the top-level parameters
	localparam int DEF_MAX_SETS = 2048;
	localparam int DEF_MAX_WAYS = 16;

	// byte address width seen by the lookup; bits above it are ignored
	localparam int ADDR_WIDTH = 32;
	localparam logic [31:0] ADDR_MASK = (ADDR_WIDTH >= 32) ? 32'hFFFF_FFFF :
		32'((64'd1 << ADDR_WIDTH) - 64'd1);

	// field widths
	localparam int IN_W      = 32;
	localparam int TAG_W     = 32;
	localparam int CNT_W     = 32;
	localparam int OUT_BITS  = 2 + TAG_W + 2 * CNT_W;
	localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 5;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

	// register reset values
	localparam logic [3:0] RST_OFFSET_BITS = 4'd6;
	localparam logic [3:0] RST_SET_BITS    = 4'd5;
	localparam logic [4:0] RST_WAYS_IN_USE = 5'd2;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FILL,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_DECIDE,
		ST_UPD_RD,
		ST_UPD_WR,
		ST_DONE
	} state_t;

endpackage

>>> design/set_assoc_cache_lru_tags.sv
// set_assoc_cache_lru_tags: tag array of a set-associative cache, true lru
// one sequencer walks the ways of a set through a single tag/rank memory port
// depends on sacl_pkg
//
// channel   dir  handshake               payload
// s_*       in   s_tvalid / s_tready     s_tdata: address
// m_*       out  m_tvalid / m_tready     m_tdata: hit, evicted, evicted_tag,
//                                                 access_total, miss_total
// cfg_*     in   cfg_we                  cfg_index, cfg_wdata
//
// a request runs from acceptance to result through a fill count read of its
// set, a compare pass over the filled ways, the decision, a rank update pass
// over the same ways and the output load; each pass reads a way, then compares
// or writes it, through the one memory port; the next request is taken in the
// cycle after the output load. after reset a clearing pass zeroes fill counts;
// s_tready is low meanwhile. a waiting result sits in the output register
// and does not stop the next request being taken; a stalled m_tready holds
// the sequencer only at the end of the following request.
module set_assoc_cache_lru_tags #(
	parameter int MAX_SETS = sacl_pkg::DEF_MAX_SETS,
	parameter int MAX_WAYS = sacl_pkg::DEF_MAX_WAYS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [sacl_pkg::IN_W-1:0]      s_tdata,   // [31:0] address
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [0] hit, [1] evicted, [33:2] evicted_tag, [65:34] access_total,
	// [97:66] miss_total, rest zero
	output logic [sacl_pkg::OUT_W-1:0]     m_tdata,
	input  logic                           cfg_we,
	input  logic [sacl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sacl_pkg::CFG_DAT_W-1:0] cfg_wdata
);

	localparam int SW       = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int WW       = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int FW       = $clog2(MAX_WAYS + 1);
	localparam int DEPTH    = MAX_SETS * MAX_WAYS;
	localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SMAX_INT = $clog2(MAX_SETS + 1) - 1;
	localparam int TW       = sacl_pkg::TAG_W;
	localparam int CW       = sacl_pkg::CNT_W;
	localparam logic [5:0]    MAXW6    = 6'(MAX_WAYS);
	localparam logic [SW-1:0] LAST_SET = SW'(MAX_SETS - 1);
	localparam logic [CW-1:0] CNT_SAT  = '1;

	// memories
	logic [TW-1:0] tag_mem  [DEPTH];
	logic [WW-1:0] rank_mem [DEPTH];
	logic [FW-1:0] fill_mem [MAX_SETS];

	// configuration
	logic [3:0] offset_q;
	logic [3:0] set_bits_q;
	logic [4:0] ways_q;

	sacl_pkg::state_t state_q, state_d;

	logic [SW-1:0] clr_q;
	logic [SW-1:0] set_q;
	logic [TW-1:0] tag_q;
	logic [AW-1:0] base_q;
	logic [FW-1:0] fill_q;
	logic [WW-1:0] way_q;
	logic          hit_q;
	logic [WW-1:0] hit_way_q;
	logic [WW-1:0] hit_rank_q;
	logic [WW-1:0] vic_way_q;
	logic [WW-1:0] vic_rank_q;
	logic [TW-1:0] vic_tag_q;
	logic          evict_q;
	logic [CW-1:0] access_q;
	logic [CW-1:0] miss_q;

	logic [TW-1:0] tag_rd_q;
	logic [WW-1:0] rank_rd_q;
	logic [FW-1:0] fill_rd_q;

	logic          out_valid_q;
	logic          out_hit_q;
	logic          out_evicted_q;
	logic [TW-1:0] out_ev_tag_q;
	logic [CW-1:0] out_access_q;
	logic [CW-1:0] out_miss_q;

	// address split
	logic [3:0]    sb_eff;
	logic [31:0]   addr_m;
	logic [31:0]   addr_sh;
	logic [31:0]   set_mask;
	logic [SW-1:0] set_in;
	logic [TW-1:0] tag_in;
	logic [5:0]    ways_eff;
	logic          fill_room;
	logic          last_way;

	// memory port controls
	logic [AW-1:0] mem_addr;
	logic          mem_re;
	logic          tag_we;
	logic          rank_we;
	logic [WW-1:0] rank_wdata;
	logic [SW-1:0] fill_addr;
	logic          fill_re;
	logic          fill_we;
	logic [FW-1:0] fill_wdata;
	logic          load_out;

	always_comb begin
		sb_eff   = (int'(set_bits_q) > SMAX_INT) ? 4'(SMAX_INT) : set_bits_q;
		addr_m   = s_tdata & sacl_pkg::ADDR_MASK;
		addr_sh  = addr_m >> offset_q;
		set_mask = (32'd1 << sb_eff) - 32'd1;
		set_in   = SW'(addr_sh & set_mask);
		tag_in   = addr_m >> (5'(offset_q) + 5'(sb_eff));
		if (ways_q == 5'd0) begin
			ways_eff = 6'd1;
		end else if ({1'b0, ways_q} > MAXW6) begin
			ways_eff = MAXW6;
		end else begin
			ways_eff = {1'b0, ways_q};
		end
		fill_room = 6'(fill_q) < ways_eff;
		last_way  = (FW'(way_q) + FW'(1)) == fill_q;
	end

	// next state and memory controls
	always_comb begin
		state_d    = state_q;
		mem_addr   = base_q + AW'(way_q);
		mem_re     = 1'b0;
		tag_we     = 1'b0;
		rank_we    = 1'b0;
		rank_wdata = '0;
		fill_addr  = set_q;
		fill_re    = 1'b0;
		fill_we    = 1'b0;
		fill_wdata = fill_q + FW'(1);
		load_out   = 1'b0;
		s_tready   = 1'b0;
		unique case (state_q)
			sacl_pkg::ST_CLEAR: begin
				fill_addr  = clr_q;
				fill_we    = 1'b1;
				fill_wdata = '0;
				if (clr_q == LAST_SET) begin
					state_d = sacl_pkg::ST_IDLE;
				end
			end
			sacl_pkg::ST_IDLE: begin
				s_tready  = 1'b1;
				fill_addr = set_in;
				if (s_tvalid) begin
					fill_re = 1'b1;
					state_d = sacl_pkg::ST_FILL;
				end
			end
			sacl_pkg::ST_FILL: begin
				if (fill_rd_q == '0) begin
					state_d = sacl_pkg::ST_DECIDE;
				end else begin
					state_d = sacl_pkg::ST_SCAN_RD;
				end
			end
			sacl_pkg::ST_SCAN_RD: begin
				mem_re  = 1'b1;
				state_d = sacl_pkg::ST_SCAN_CMP;
			end
			sacl_pkg::ST_SCAN_CMP: begin
				state_d = last_way ? sacl_pkg::ST_DECIDE : sacl_pkg::ST_SCAN_RD;
			end
			sacl_pkg::ST_DECIDE: begin
				if (!hit_q && fill_room) begin
					// free way: new tag goes in at the fill position
					mem_addr   = base_q + AW'(fill_q);
					tag_we     = 1'b1;
					rank_we    = 1'b1;
					rank_wdata = '0;
					fill_we    = 1'b1;
				end else if (!hit_q) begin
					mem_addr = base_q + AW'(vic_way_q);
					tag_we   = 1'b1;
				end
				state_d = (fill_q == '0) ? sacl_pkg::ST_DONE : sacl_pkg::ST_UPD_RD;
			end
			sacl_pkg::ST_UPD_RD: begin
				mem_re  = 1'b1;
				state_d = sacl_pkg::ST_UPD_WR;
			end
			sacl_pkg::ST_UPD_WR: begin
				rank_we = 1'b1;
				if (hit_q) begin
					if (way_q == hit_way_q) begin
						rank_wdata = '0;
					end else if (rank_rd_q < hit_rank_q) begin
						rank_wdata = rank_rd_q + WW'(1);
					end else begin
						rank_wdata = rank_rd_q;
					end
				end else if (evict_q && way_q == vic_way_q) begin
					rank_wdata = '0;
				end else begin
					rank_wdata = rank_rd_q + WW'(1);
				end
				state_d = last_way ? sacl_pkg::ST_DONE : sacl_pkg::ST_UPD_RD;
			end
			sacl_pkg::ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = sacl_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sacl_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sacl_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q   <= sacl_pkg::RST_OFFSET_BITS;
			set_bits_q <= sacl_pkg::RST_SET_BITS;
			ways_q     <= sacl_pkg::RST_WAYS_IN_USE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sacl_pkg::CFG_OFFSET_BITS: offset_q   <= cfg_wdata[3:0];
				sacl_pkg::CFG_SET_BITS:    set_bits_q <= cfg_wdata[3:0];
				sacl_pkg::CFG_WAYS_IN_USE: ways_q     <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// sequencer control state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			hit_q       <= 1'b0;
			evict_q     <= 1'b0;
			way_q       <= '0;
			access_q    <= '0;
			miss_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				sacl_pkg::ST_CLEAR: begin
					clr_q <= clr_q + SW'(1);
				end
				sacl_pkg::ST_FILL: begin
					hit_q   <= 1'b0;
					evict_q <= 1'b0;
					way_q   <= '0;
				end
				sacl_pkg::ST_SCAN_CMP: begin
					if (!hit_q && tag_rd_q == tag_q) begin
						hit_q <= 1'b1;
					end
					if (!last_way) begin
						way_q <= way_q + WW'(1);
					end
				end
				sacl_pkg::ST_DECIDE: begin
					way_q    <= '0;
					evict_q  <= !hit_q && !fill_room;
					access_q <= (access_q == CNT_SAT) ? access_q : access_q + CW'(1);
					if (!hit_q && miss_q != CNT_SAT) begin
						miss_q <= miss_q + CW'(1);
					end
				end
				sacl_pkg::ST_UPD_WR: begin
					if (!last_way) begin
						way_q <= way_q + WW'(1);
					end
				end
				default: begin
				end
			endcase
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request payload, way scan results and output payload
	always_ff @(posedge clk) begin
		if (state_q == sacl_pkg::ST_IDLE && s_tvalid) begin
			set_q <= set_in;
			tag_q <= tag_in;
		end
		if (state_q == sacl_pkg::ST_FILL) begin
			fill_q <= fill_rd_q;
			base_q <= AW'(set_q) * AW'(MAX_WAYS);
		end
		if (state_q == sacl_pkg::ST_SCAN_CMP) begin
			if (!hit_q && tag_rd_q == tag_q) begin
				hit_way_q  <= way_q;
				hit_rank_q <= rank_rd_q;
			end
			// first way with the largest rank is the victim
			if (way_q == '0 || rank_rd_q > vic_rank_q) begin
				vic_way_q  <= way_q;
				vic_rank_q <= rank_rd_q;
				vic_tag_q  <= tag_rd_q;
			end
		end
		if (load_out) begin
			out_hit_q     <= hit_q;
			out_evicted_q <= evict_q;
			out_ev_tag_q  <= evict_q ? vic_tag_q : '0;
			out_access_q  <= access_q;
			out_miss_q    <= miss_q;
		end
	end

	// tag and rank memories, one address per cycle
	always_ff @(posedge clk) begin
		if (tag_we) begin
			tag_mem[mem_addr] <= tag_q;
		end
		if (rank_we) begin
			rank_mem[mem_addr] <= rank_wdata;
		end
		if (mem_re) begin
			tag_rd_q  <= tag_mem[mem_addr];
			rank_rd_q <= rank_mem[mem_addr];
		end
	end

	// fill count memory
	always_ff @(posedge clk) begin
		if (fill_we) begin
			fill_mem[fill_addr] <= fill_wdata;
		end
		if (fill_re) begin
			fill_rd_q <= fill_mem[fill_addr];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(sacl_pkg::OUT_W - sacl_pkg::OUT_BITS)'(0), out_miss_q, out_access_q,
		out_ev_tag_q, out_evicted_q, out_hit_q};

endmodule

>>> test/lru_lookup_monitor.sv
`timescale 1ns / 100ps
// lru_lookup_monitor: predicts and checks each lookup of the set-associative lru tag array
// watches the request, result and register write channels; depends on sacl_pkg
module lru_lookup_monitor (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [sacl_pkg::IN_W-1:0]      s_tdata,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [sacl_pkg::OUT_W-1:0]     m_tdata,
	input  logic                           cfg_we,
	input  logic [sacl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sacl_pkg::CFG_DAT_W-1:0] cfg_wdata,
	output int                             pending,
	output int                             fail_count
);

	localparam int SETS = sacl_pkg::DEF_MAX_SETS;
	localparam int WAYS = sacl_pkg::DEF_MAX_WAYS;
	localparam int SET_BITS_CAP = $clog2(sacl_pkg::DEF_MAX_SETS);

	// same bit order as m_tdata, hit in bit 0
	typedef struct packed {
		logic [sacl_pkg::CNT_W-1:0] miss_total;
		logic [sacl_pkg::CNT_W-1:0] access_total;
		logic [sacl_pkg::TAG_W-1:0] evicted_tag;
		logic                       evicted;
		logic                       hit;
	} lookup_t;

	logic [3:0]                 offset_bits;
	logic [3:0]                 set_bits;
	logic [4:0]                 ways_in_use;
	logic [sacl_pkg::TAG_W-1:0] tags [SETS*WAYS];
	logic [3:0]                 rank [SETS*WAYS];
	logic [4:0]                 fill [SETS];
	logic [sacl_pkg::CNT_W-1:0] accesses;
	logic [sacl_pkg::CNT_W-1:0] misses;
	lookup_t                    lookups_due [$];
	int                         mismatches = 0;

	assign fail_count = mismatches;

	task automatic predict_lookup(input logic [sacl_pkg::IN_W-1:0] addr, output lookup_t res);
		int sb, nways, set_idx, base, cnt, hit_way, victim, w;
		logic [sacl_pkg::IN_W-1:0] masked;
		logic [sacl_pkg::TAG_W-1:0] tag;
		masked = addr & sacl_pkg::ADDR_MASK;
		sb = (set_bits > SET_BITS_CAP) ? SET_BITS_CAP : int'(set_bits);
		nways = (ways_in_use == 0) ? 1 : (ways_in_use > WAYS) ? WAYS : int'(ways_in_use);
		set_idx = int'((masked >> offset_bits) & ((32'd1 << sb) - 32'd1));
		tag = masked >> (int'(offset_bits) + sb);
		base = set_idx * WAYS;
		cnt = (fill[set_idx] > WAYS) ? WAYS : int'(fill[set_idx]);
		hit_way = -1;
		for (w = 0; w < cnt; w++)
			if (hit_way < 0 && tags[base + w] == tag)
				hit_way = w;
		res = '0;
		if (accesses != '1)
			accesses++;
		if (hit_way >= 0) begin
			res.hit = 1'b1;
			for (w = 0; w < cnt; w++)
				if (rank[base + w] < rank[base + hit_way])
					rank[base + w]++;
			rank[base + hit_way] = '0;
		end else begin
			if (misses != '1)
				misses++;
			if (cnt < nways) begin
				for (w = 0; w < cnt; w++)
					rank[base + w]++;
				tags[base + cnt] = tag;
				rank[base + cnt] = '0;
				fill[set_idx] = 5'(cnt + 1);
			end else begin
				// set full, or holding more ways than now in use
				victim = 0;
				for (w = 1; w < cnt; w++)
					if (rank[base + w] > rank[base + victim])
						victim = w;
				res.evicted = 1'b1;
				res.evicted_tag = tags[base + victim];
				for (w = 0; w < cnt; w++)
					rank[base + w]++;
				tags[base + victim] = tag;
				rank[base + victim] = '0;
			end
		end
		res.access_total = accesses;
		res.miss_total = misses;
	endtask

	task automatic compare_field(input string label, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, label, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		lookup_t want, got;
		if (!arst_n) begin
			offset_bits = sacl_pkg::RST_OFFSET_BITS;
			set_bits = sacl_pkg::RST_SET_BITS;
			ways_in_use = sacl_pkg::RST_WAYS_IN_USE;
			foreach (fill[i])
				fill[i] = '0;
			accesses = '0;
			misses = '0;
			lookups_due.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					sacl_pkg::CFG_OFFSET_BITS: offset_bits = cfg_wdata[3:0];
					sacl_pkg::CFG_SET_BITS:    set_bits = cfg_wdata[3:0];
					sacl_pkg::CFG_WAYS_IN_USE: ways_in_use = cfg_wdata;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				predict_lookup(s_tdata, want);
				lookups_due.insert(lookups_due.size(), want);
			end
			if (m_tvalid && m_tready) begin
				got = m_tdata[$bits(lookup_t)-1:0];
				if (lookups_due.size() == 0) begin
					$display("%0t: result with none due: expected none, actual %h", $time, got);
					mismatches++;
				end else begin
					want = lookups_due.pop_front();
					compare_field("hit", 32'(want.hit), 32'(got.hit));
					compare_field("evicted", 32'(want.evicted), 32'(got.evicted));
					compare_field("evicted_tag", want.evicted_tag, got.evicted_tag);
					compare_field("access_total", want.access_total, got.access_total);
					compare_field("miss_total", want.miss_total, got.miss_total);
				end
			end
		end
		pending = lookups_due.size();
	end

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps
// tb: top of the set-associative lru tag array testbench, makes requests, result
// stalls and register writes and gives the verdict
// depends on sacl_pkg, set_assoc_cache_lru_tags and lru_lookup_monitor
module tb;

	localparam int QUIET_LIMIT = 20000;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_ITEMS = 128;
	localparam int SET_BITS_CAP = $clog2(sacl_pkg::DEF_MAX_SETS);

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [sacl_pkg::IN_W-1:0]      s_tdata = '0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [sacl_pkg::OUT_W-1:0]     m_tdata;
	logic                           cfg_we = 1'b0;
	logic [sacl_pkg::CFG_IDX_W-1:0] cfg_index = sacl_pkg::CFG_OFFSET_BITS;
	logic [sacl_pkg::CFG_DAT_W-1:0] cfg_wdata = '0;
	logic                           calm = 1'b0;
	int                             pending;
	int                             fail_count;
	int                             quiet_cycles = 0;
	// address split in effect, for building addresses
	int                             offset_now = int'(sacl_pkg::RST_OFFSET_BITS);
	int                             sets_now = int'(sacl_pkg::RST_SET_BITS);
	int                             ways_now = int'(sacl_pkg::RST_WAYS_IN_USE);

	// fixed settings for the first random phases, extremes among them
	int plan_off [7] = '{0, 12, 15, 3, 12, 0, 6};
	int plan_sb [7] = '{0, 11, 15, 2, 0, 11, 5};
	int plan_ways [7] = '{1, 16, 31, 4, 17, 0, 2};

	set_assoc_cache_lru_tags uut (.*);
	lru_lookup_monitor mon (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk)
		m_tready <= calm || ($urandom_range(99, 0) >= 26);

	always @(posedge clk)
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;

	initial begin
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("status: fail");
		$finish;
	end

	task automatic send_address(input logic [sacl_pkg::IN_W-1:0] addr);
		if (!calm && $urandom_range(99, 0) < 26) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while (!calm && $urandom_range(99, 0) < 26);
		end
		s_tvalid <= 1'b1;
		s_tdata <= addr;
		do @(negedge clk); while (s_tready !== 1'b1);
		@(posedge clk);
	endtask

	// called in the step of the last acceptance, so tvalid drops right there
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	task automatic configure(input logic [4:0] off, input logic [4:0] sb, input logic [4:0] ways);
		cfg_we <= 1'b1;
		cfg_index <= sacl_pkg::CFG_OFFSET_BITS;
		cfg_wdata <= off;
		@(posedge clk);
		cfg_index <= sacl_pkg::CFG_SET_BITS;
		cfg_wdata <= sb;
		@(posedge clk);
		cfg_index <= sacl_pkg::CFG_WAYS_IN_USE;
		cfg_wdata <= ways;
		@(posedge clk);
		cfg_we <= 1'b0;
		offset_now = int'(off[3:0]);
		sets_now = (sb[3:0] > SET_BITS_CAP) ? SET_BITS_CAP : int'(sb[3:0]);
		ways_now = (ways == 0) ? 1 :
			(ways > sacl_pkg::DEF_MAX_WAYS) ? sacl_pkg::DEF_MAX_WAYS : int'(ways);
	endtask

	function automatic logic [sacl_pkg::IN_W-1:0] compose(input logic [31:0] tag,
			input logic [31:0] set_idx, input logic [31:0] low);
		return (tag << (offset_now + sets_now)) |
			((set_idx & ((32'd1 << sets_now) - 1)) << offset_now) |
			(low & ((32'd1 << offset_now) - 1));
	endfunction

	// a few sets and a tag pool a little larger than the ways, so that hits and
	// lru evictions both come often; the rest is fully random addresses
	task automatic run_phase(input int count);
		logic [31:0] tag_pool [20];
		logic [31:0] set_pool [4];
		logic [sacl_pkg::IN_W-1:0] addr;
		int n_tags;
		n_tags = ways_now + 1 + int'($urandom_range(3, 0));
		foreach (tag_pool[i])
			tag_pool[i] = $urandom;
		foreach (set_pool[i])
			set_pool[i] = $urandom;
		repeat (count) begin
			if ($urandom_range(99, 0) < 15)
				addr = $urandom;
			else
				addr = compose(tag_pool[$urandom_range(n_tags - 1, 0)],
					set_pool[$urandom_range(3, 0)], $urandom);
			send_address(addr);
		end
		drain();
	endtask

	initial begin
		int p;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset split: fills, a hit, then lru evictions in set 0
		send_address(32'h0000_0000);
		send_address(32'hFFFF_FFFF);
		send_address(32'h0000_0000);
		send_address(32'h0000_0800);
		send_address(32'h0000_1000);
		send_address(32'h0000_0800);
		send_address(32'h0000_003F);
		drain();

		// fewer ways than set 0 holds: no fill, lru way replaced
		configure(5'd6, 5'd5, 5'd1);
		send_address(32'h0000_1000);
		send_address(32'h0000_0000);
		drain();

		// widest offset, set bits beyond the cap, zero ways
		configure(5'd15, 5'd15, 5'd0);
		send_address(32'hFFFF_FFFF);
		send_address(32'hFFFF_FFFF);
		send_address(32'h7FFF_FFFF);
		drain();

		for (p = 0; p < RANDOM_PHASES; p++) begin
			if (p < 7)
				configure(5'(plan_off[p]), 5'(plan_sb[p]), 5'(plan_ways[p]));
			else
				configure(5'($urandom_range(31, 0)), 5'($urandom_range(31, 0)),
					5'($urandom_range(31, 0)));
			calm <= (p == 3);
			run_phase(PHASE_ITEMS);
		end

		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
